>>> rtl/mbq_pkg.sv
// ============================================================================
// mbq_pkg
// Shared types, codes and default sizes for the named mailbox queue engine.
// ============================================================================
package mbq_pkg;

    // Default sizes for the top-level parameters
    localparam int ENDPOINTS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MSG_BYTES_DEF   = 64;
    localparam int NAME_BYTES_DEF  = 8;

    // Fixed field widths
    localparam int ID_W       = 22;
    localparam int KEY_W      = 64;
    localparam int CAP_W      = 16;
    localparam int STATUS_W   = 4;
    localparam int LEN_W      = 7;
    localparam int QLIM_W     = 5;
    localparam int MLIM_W     = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Register reset values and indexes
    localparam logic [QLIM_W-1:0]    QLIM_RESET        = 5'd10;
    localparam logic [MLIM_W-1:0]    MLIM_RESET        = 7'd64;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        MODE_REG   = 2'd0,
        MODE_UNREG = 2'd1,
        MODE_SEND  = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 4'd0,
        ST_UNREG         = 4'd1,
        ST_NAME_MISMATCH = 4'd2,
        ST_TOO_LONG      = 4'd3,
        ST_EMPTY         = 4'd4,
        ST_ID_EXISTS     = 4'd5,
        ST_NAME_TAKEN    = 4'd6,
        ST_UNKNOWN_DEST  = 4'd7,
        ST_BUF_SMALL     = 4'd8,
        ST_TABLE_FULL    = 4'd9
    } status_t;

    // What the engine does after the decision cycle
    typedef enum logic [1:0] {
        ACT_RESP,
        ACT_COPY,
        ACT_READ
    } act_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic match;
        logic enc;
        logic decide;
        logic copy_step;
        logic fin;
        logic rd_issue;
        logic rd_emit;
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        act_t act;
        logic out_free;
        logic copy_more;
        logic rd_last;
    } dp_status_t;

endpackage

>>> rtl/mbq_ram.sv
// ============================================================================
// mbq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module mbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/mbq_datapath.sv
// ============================================================================
// mbq_datapath
// Endpoint table, queue pointers, staging buffer, message memories and the
// output register of the mailbox engine.
// ============================================================================
module mbq_datapath
    import mbq_pkg::*;
#(
    parameter int ENDPOINTS   = ENDPOINTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MSG_BYTES   = MSG_BYTES_DEF,
    parameter int NAME_BYTES  = NAME_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            st,
    // item fields
    input  mode_t                 mode,
    input  logic [ID_W-1:0]       caller_id,
    input  logic [KEY_W-1:0]      name_key,
    input  logic [7:0]            data_byte,
    input  logic                  byte_present,
    input  logic                  last_byte,
    input  logic [CAP_W-1:0]      reader_capacity,
    // register writes
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // result register
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   out_status,
    output logic [7:0]            out_byte,
    output logic                  out_flag,
    output logic [LEN_W-1:0]      out_len,
    output logic                  out_last
);

    localparam int EW       = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
    localparam int QW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW       = $clog2(QUEUE_DEPTH + 1);
    localparam int SW       = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
    localparam int SCW      = $clog2(MSG_BYTES + 1);
    localparam int NW       = 8 * NAME_BYTES;
    localparam int SZ_DEPTH = ENDPOINTS * QUEUE_DEPTH;
    localparam int SZA      = (SZ_DEPTH > 1) ? $clog2(SZ_DEPTH) : 1;
    localparam int MB_DEPTH = SZ_DEPTH * MSG_BYTES;
    localparam int MBA      = (MB_DEPTH > 1) ? $clog2(MB_DEPTH) : 1;

    // Latched item
    mode_t              mode_reg;
    logic [ID_W-1:0]    id_reg;
    logic [NW-1:0]      key_reg;
    logic               last_reg;
    logic [CAP_W-1:0]   cap_reg;

    // Configuration
    logic [QLIM_W-1:0]  qlim_reg;
    logic [MLIM_W-1:0]  mlim_reg;

    // Endpoint table
    logic               slot_used_reg  [ENDPOINTS];
    logic [ID_W-1:0]    slot_owner_reg [ENDPOINTS];
    logic [NW-1:0]      slot_name_reg  [ENDPOINTS];
    logic [QW-1:0]      head_reg       [ENDPOINTS];
    logic [CW-1:0]      count_reg      [ENDPOINTS];

    // Lookup pipeline
    logic [ENDPOINTS-1:0] owner_vec_reg, name_vec_reg, free_vec_reg;
    logic [ENDPOINTS-1:0] owner_m, name_m, free_m;
    logic [EW-1:0]      owner_idx_c, name_idx_c, free_idx_c;
    logic               owner_any_c, name_any_c, free_any_c;
    logic [EW-1:0]      owner_idx_reg, name_idx_reg, free_idx_reg;
    logic               owner_any_reg, name_any_reg, free_any_reg, same_reg;

    // Staging
    logic [SCW-1:0]     scount_reg;
    logic               sovf_reg;
    logic               stage_wr;

    // Copy and read sequencing
    logic [SCW-1:0]     copy_idx_reg;
    logic               wr_pending_reg;
    logic [SW-1:0]      wr_k_reg;
    logic [SZA-1:0]     wbase_reg, rbase_reg;
    logic [LEN_W-1:0]   rd_idx_reg, rd_len_reg;

    // Output register
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [7:0]         out_byte_reg;
    logic               out_flag_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic               out_last_reg;
    logic               out_load;

    // Memory ports
    logic [LEN_W-1:0]   sz_rd_data;
    logic [SZA-1:0]     sz_rd_addr;
    logic [7:0]         stage_rd_data;
    logic [7:0]         msg_rd_data;

    // Decision
    logic [15:0]        ql_eff, ml_eff, pos_w, size_w;
    logic               drop;
    logic [QW-1:0]      head_t, head1, head_o, head_pop;
    logic [CW-1:0]      cnt_t, cnt1, cnt_o;
    logic [SZA-1:0]     wbase_c, rbase_c;
    status_t            dec_status;
    act_t               dec_act;

    // Per-endpoint compares
    always_comb
    begin
        for (int i = 0; i < ENDPOINTS; i++)
        begin
            owner_m[i] = slot_used_reg[i] && (slot_owner_reg[i] == id_reg);
            name_m[i]  = slot_used_reg[i] && (slot_name_reg[i] == key_reg);
            free_m[i]  = !slot_used_reg[i];
        end
    end

    // Lowest-index encoders
    always_comb
    begin
        owner_idx_c = '0;
        name_idx_c  = '0;
        free_idx_c  = '0;
        owner_any_c = 1'b0;
        name_any_c  = 1'b0;
        free_any_c  = 1'b0;
        for (int i = ENDPOINTS - 1; i >= 0; i--)
        begin
            if (owner_vec_reg[i])
            begin
                owner_idx_c = EW'(i);
                owner_any_c = 1'b1;
            end
            if (name_vec_reg[i])
            begin
                name_idx_c = EW'(i);
                name_any_c = 1'b1;
            end
            if (free_vec_reg[i])
            begin
                free_idx_c = EW'(i);
                free_any_c = 1'b1;
            end
        end
    end

    assign sz_rd_addr = SZA'(owner_idx_c) * SZA'(QUEUE_DEPTH) + SZA'(head_reg[owner_idx_c]);

    // Decision from the registered lookup and the head size
    always_comb
    begin
        ql_eff = (qlim_reg == '0) ? 16'd1 :
                 ((16'(qlim_reg) > 16'(QUEUE_DEPTH)) ? 16'(QUEUE_DEPTH) : 16'(qlim_reg));
        ml_eff = (16'(mlim_reg) > 16'(MSG_BYTES)) ? 16'(MSG_BYTES) : 16'(mlim_reg);

        // send target: drop oldest when full, then append
        head_t = head_reg[name_idx_reg];
        cnt_t  = count_reg[name_idx_reg];
        drop   = 16'(cnt_t) >= ql_eff;
        head1  = drop ? ((head_t == QW'(QUEUE_DEPTH - 1)) ? '0 : head_t + QW'(1)) : head_t;
        cnt1   = drop ? cnt_t - CW'(1) : cnt_t;
        pos_w  = 16'(head1) + 16'(cnt1);
        if (pos_w >= 16'(QUEUE_DEPTH))
        begin
            pos_w = pos_w - 16'(QUEUE_DEPTH);
        end
        wbase_c = SZA'(name_idx_reg) * SZA'(QUEUE_DEPTH) + SZA'(pos_w);

        // reader's own queue
        head_o   = head_reg[owner_idx_reg];
        cnt_o    = count_reg[owner_idx_reg];
        rbase_c  = SZA'(owner_idx_reg) * SZA'(QUEUE_DEPTH) + SZA'(head_o);
        head_pop = (head_o == QW'(QUEUE_DEPTH - 1)) ? '0 : head_o + QW'(1);
        size_w   = 16'(sz_rd_data);

        dec_status = ST_OK;
        dec_act    = ACT_RESP;
        unique case (mode_reg)
            MODE_REG:
            begin
                priority if (key_reg == '0)  dec_status = ST_EMPTY;
                else if (owner_any_reg)     dec_status = ST_ID_EXISTS;
                else if (name_any_reg)      dec_status = ST_NAME_TAKEN;
                else if (!free_any_reg)     dec_status = ST_TABLE_FULL;
                else                        dec_status = ST_OK;
            end
            MODE_UNREG:
            begin
                priority if (!owner_any_reg) dec_status = ST_UNREG;
                else if (!same_reg)         dec_status = ST_NAME_MISMATCH;
                else                        dec_status = ST_OK;
            end
            MODE_SEND:
            begin
                if (last_reg)
                begin
                    priority if (scount_reg == '0 && !sovf_reg)        dec_status = ST_EMPTY;
                    else if (!name_any_reg)                           dec_status = ST_UNKNOWN_DEST;
                    else if (sovf_reg || 16'(scount_reg) > ml_eff)    dec_status = ST_TOO_LONG;
                    else                                              dec_act = ACT_COPY;
                end
            end
            MODE_READ:
            begin
                priority if (!owner_any_reg)  dec_status = ST_UNREG;
                else if (cnt_o == '0)        dec_status = ST_OK;
                else if (16'(cap_reg) < size_w) dec_status = ST_BUF_SMALL;
                else if (size_w == 16'd0)    dec_status = ST_OK;
                else                         dec_act = ACT_READ;
            end
        endcase
    end

    assign out_load = (cmd.decide && dec_act == ACT_RESP) || cmd.fin || cmd.rd_emit;
    assign stage_wr = cmd.load && mode == MODE_SEND && byte_present
                      && (32'(scount_reg) < MSG_BYTES);

    assign st.act       = dec_act;
    assign st.out_free  = !out_valid_reg || out_ready;
    assign st.copy_more = copy_idx_reg < scount_reg;
    assign st.rd_last   = (rd_idx_reg + LEN_W'(1)) == rd_len_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlim_reg       <= QLIM_RESET;
            mlim_reg       <= MLIM_RESET;
            scount_reg     <= '0;
            sovf_reg       <= 1'b0;
            wr_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < ENDPOINTS; i++)
            begin
                slot_used_reg[i] <= 1'b0;
                head_reg[i]      <= '0;
                count_reg[i]     <= '0;
            end
        end
        else
        begin
            // register writes
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    CFG_QUEUE_LIMIT:   qlim_reg <= cfg_data[QLIM_W-1:0];
                    CFG_MESSAGE_LIMIT: mlim_reg <= cfg_data;
                endcase
            end

            // staging a byte on accept
            if (cmd.load && mode == MODE_SEND && byte_present)
            begin
                if (32'(scount_reg) < MSG_BYTES)
                begin
                    scount_reg <= scount_reg + SCW'(1);
                end
                else
                begin
                    sovf_reg <= 1'b1;
                end
            end

            // table and queue updates
            if (cmd.decide)
            begin
                unique case (mode_reg)
                    MODE_REG:
                    begin
                        if (dec_status == ST_OK)
                        begin
                            slot_used_reg[free_idx_reg] <= 1'b1;
                            head_reg[free_idx_reg]      <= '0;
                            count_reg[free_idx_reg]     <= '0;
                        end
                    end
                    MODE_UNREG:
                    begin
                        if (dec_status == ST_OK)
                        begin
                            slot_used_reg[owner_idx_reg] <= 1'b0;
                            head_reg[owner_idx_reg]      <= '0;
                            count_reg[owner_idx_reg]     <= '0;
                        end
                    end
                    MODE_SEND:
                    begin
                        if (last_reg)
                        begin
                            if (dec_act == ACT_COPY)
                            begin
                                head_reg[name_idx_reg]  <= head1;
                                count_reg[name_idx_reg] <= cnt1 + CW'(1);
                            end
                            else
                            begin
                                scount_reg <= '0;
                                sovf_reg   <= 1'b0;
                            end
                        end
                    end
                    MODE_READ:
                    begin
                    end
                endcase
            end

            if (cmd.fin)
            begin
                scount_reg <= '0;
                sovf_reg   <= 1'b0;
            end

            // pop after the last byte goes out
            if (cmd.rd_emit && st.rd_last)
            begin
                head_reg[owner_idx_reg]  <= head_pop;
                count_reg[owner_idx_reg] <= cnt_o - CW'(1);
            end

            wr_pending_reg <= cmd.copy_step;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            id_reg   <= caller_id;
            key_reg  <= name_key[NW-1:0];
            last_reg <= last_byte;
            cap_reg  <= reader_capacity;
        end
        if (cmd.match)
        begin
            owner_vec_reg <= owner_m;
            name_vec_reg  <= name_m;
            free_vec_reg  <= free_m;
        end
        if (cmd.enc)
        begin
            owner_idx_reg <= owner_idx_c;
            name_idx_reg  <= name_idx_c;
            free_idx_reg  <= free_idx_c;
            owner_any_reg <= owner_any_c;
            name_any_reg  <= name_any_c;
            free_any_reg  <= free_any_c;
            same_reg      <= |(owner_vec_reg & name_vec_reg);
        end
        if (cmd.decide)
        begin
            if (mode_reg == MODE_REG && dec_status == ST_OK)
            begin
                slot_owner_reg[free_idx_reg] <= id_reg;
                slot_name_reg[free_idx_reg]  <= key_reg;
            end
            wbase_reg    <= wbase_c;
            rbase_reg    <= rbase_c;
            rd_len_reg   <= sz_rd_data;
            rd_idx_reg   <= '0;
            copy_idx_reg <= '0;
        end
        if (cmd.copy_step)
        begin
            copy_idx_reg <= copy_idx_reg + SCW'(1);
            wr_k_reg     <= SW'(copy_idx_reg);
        end
        if (cmd.rd_emit)
        begin
            rd_idx_reg <= rd_idx_reg + LEN_W'(1);
        end

        // result beat
        if (cmd.decide && dec_act == ACT_RESP)
        begin
            out_status_reg <= dec_status;
            out_byte_reg   <= '0;
            out_flag_reg   <= 1'b0;
            out_len_reg    <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.fin)
        begin
            out_status_reg <= ST_OK;
            out_byte_reg   <= '0;
            out_flag_reg   <= 1'b0;
            out_len_reg    <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.rd_emit)
        begin
            out_status_reg <= ST_OK;
            out_byte_reg   <= msg_rd_data;
            out_flag_reg   <= 1'b1;
            out_len_reg    <= rd_len_reg;
            out_last_reg   <= st.rd_last;
        end
    end

    // Message sizes, one per queue entry
    mbq_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SZ_DEPTH)
    ) u_sizes (
        .clk     (clk),
        .wr_en   (cmd.decide && dec_act == ACT_COPY),
        .wr_addr (wbase_c),
        .wr_data (LEN_W'(scount_reg)),
        .rd_en   (cmd.enc),
        .rd_addr (sz_rd_addr),
        .rd_data (sz_rd_data)
    );

    // Staging buffer for the message being sent
    mbq_ram #(
        .WIDTH (8),
        .DEPTH (MSG_BYTES)
    ) u_stage (
        .clk     (clk),
        .wr_en   (stage_wr),
        .wr_addr (SW'(scount_reg)),
        .wr_data (data_byte),
        .rd_en   (cmd.copy_step),
        .rd_addr (SW'(copy_idx_reg)),
        .rd_data (stage_rd_data)
    );

    // Message bytes for all queues
    mbq_ram #(
        .WIDTH (8),
        .DEPTH (MB_DEPTH)
    ) u_msgs (
        .clk     (clk),
        .wr_en   (wr_pending_reg),
        .wr_addr (MBA'(wbase_reg) * MBA'(MSG_BYTES) + MBA'(wr_k_reg)),
        .wr_data (stage_rd_data),
        .rd_en   (cmd.rd_issue),
        .rd_addr (MBA'(rbase_reg) * MBA'(MSG_BYTES) + MBA'(rd_idx_reg)),
        .rd_data (msg_rd_data)
    );

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_byte   = out_byte_reg;
    assign out_flag   = out_flag_reg;
    assign out_len    = out_len_reg;
    assign out_last   = out_last_reg;

`ifndef ASSERT_OFF
    // a waiting result beat is never overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !out_load)
        else $error("result register overwritten while stalled");

    // staging fill never passes the buffer size
    a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(scount_reg) <= MSG_BYTES)
        else $error("staging count out of range");

    // a copy write is finished before the next item is taken
    a_copy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !wr_pending_reg)
        else $error("item accepted during message copy");
`endif

endmodule

>>> rtl/mbq_ctrl.sv
// ============================================================================
// mbq_ctrl
// Sequencer of the mailbox engine: lookup, decision, copy and read steps.
// ============================================================================
module mbq_ctrl
    import mbq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_ENC,
        S_DECIDE,
        S_COPY,
        S_FIN,
        S_RD_ADDR,
        S_RD_DATA
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.match  = 1'b1;
                state_next = S_ENC;
            end
            S_ENC:
            begin
                cmd.enc    = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                unique case (st.act)
                    ACT_COPY:
                    begin
                        cmd.decide = 1'b1;
                        state_next = S_COPY;
                    end
                    ACT_READ:
                    begin
                        cmd.decide = 1'b1;
                        state_next = S_RD_ADDR;
                    end
                    default:
                    begin
                        if (st.out_free)
                        begin
                            cmd.decide = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_COPY:
            begin
                if (st.copy_more)
                begin
                    cmd.copy_step = 1'b1;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD_ADDR:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                if (st.out_free)
                begin
                    cmd.rd_emit = 1'b1;
                    state_next  = st.rd_last ? S_IDLE : S_RD_ADDR;
                end
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

>>> rtl/named_mailbox_drop_oldest_queue_core.sv
// ============================================================================
// named_mailbox_drop_oldest_queue_core
// Named mailbox engine: endpoint table with bounded drop-oldest byte queues.
// ============================================================================
//
// Channel   Dir  Beat contents
// s_*       in   tdata: caller_id, name_key, data_byte, reader_capacity
//                tuser: mode, byte_present   tlast: last_byte
// m_*       out  tdata: status, out_byte, message_length
//                tuser: out_flag             tlast: end_of_run
// cfg_*     in   cfg_index 0 queue_limit, 1 message_limit; cfg_data value
//
// Register, unregister and non-final send beats step through accept, table
// compare, encode and decide. A committed send then copies the n-byte message
// from the staging buffer into the message memory, one byte per cycle.
// A read runs the same steps, then a message memory read and a result load per byte.
// Reset clears endpoint flags and queue pointers at once; no clearing pass.
// A stalled result beat holds the engine until it is taken.
//
module named_mailbox_drop_oldest_queue_core
    import mbq_pkg::*;
#(
    parameter int ENDPOINTS   = ENDPOINTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MSG_BYTES   = MSG_BYTES_DEF,
    parameter int NAME_BYTES  = NAME_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [111:0]          s_tdata,  // caller_id[21:0], name_key[85:22],
                                            // data_byte[93:86], reader_capacity[109:94]
    input  logic [2:0]            s_tuser,  // mode[1:0], byte_present[2]
    input  logic                  s_tlast,  // last_byte
    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,  // status[3:0], out_byte[11:4],
                                            // message_length[18:12]
    output logic                  m_tuser,  // out_flag, set on message byte beats
    output logic                  m_tlast,  // end_of_run
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t          cmd;
    dp_status_t         st;
    logic [STATUS_W-1:0] out_status;
    logic [7:0]         out_byte;
    logic [LEN_W-1:0]   out_len;

    assign cfg_ready = 1'b1;

    mbq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    mbq_datapath #(
        .ENDPOINTS   (ENDPOINTS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MSG_BYTES   (MSG_BYTES),
        .NAME_BYTES  (NAME_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .mode            (mode_t'(s_tuser[1:0])),
        .caller_id       (s_tdata[21:0]),
        .name_key        (s_tdata[85:22]),
        .data_byte       (s_tdata[93:86]),
        .byte_present    (s_tuser[2]),
        .last_byte       (s_tlast),
        .reader_capacity (s_tdata[109:94]),
        .cfg_wr          (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_status      (out_status),
        .out_byte        (out_byte),
        .out_flag        (m_tuser),
        .out_len         (out_len),
        .out_last        (m_tlast)
    );

    assign m_tdata = {5'b0, out_len, out_byte, out_status};

endmodule
